// ----- rtl/mahl_pkg.sv -----
// Shared types for the MIPS-style ALU with HI/LO: command codes, beat
// structs and the HI/LO state and update groups. No dependencies.
package mahl_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CmdW   = 5;
  localparam int unsigned ShamtW = 5;
  localparam int unsigned UpperShift = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_CHK  = 5'd0,
    CMD_ADD_WRAP = 5'd1,
    CMD_SUB_CHK  = 5'd2,
    CMD_AND      = 5'd3,
    CMD_OR       = 5'd4,
    CMD_XOR      = 5'd5,
    CMD_NOR      = 5'd6,
    CMD_NAND     = 5'd7,
    CMD_SLT      = 5'd8,
    CMD_SLL      = 5'd9,
    CMD_SRL      = 5'd10,
    CMD_SRA      = 5'd11,
    CMD_MULT     = 5'd12,
    CMD_MULTU    = 5'd13,
    CMD_MFHI     = 5'd14,
    CMD_MFLO     = 5'd15,
    CMD_LUI      = 5'd16
  } cmd_t;

  typedef struct packed {
    logic        [CmdW-1:0]   command;
    logic signed [WordW-1:0]  operand_a;
    logic signed [WordW-1:0]  operand_b;
    logic        [ShamtW-1:0] shift_amount;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordW-1:0] result;
    logic                    overflow;
    logic                    hilo_overwrite;
  } out_beat_t;

  typedef struct packed {
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
    logic             pending;
  } hilo_state_t;

  typedef struct packed {
    logic             write_product;
    logic             clear_pending;
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
  } hilo_upd_t;

endpackage

// ----- rtl/mahl_hilo.sv -----
// HI/LO product registers and the pending mark.
// Depends on mahl_pkg for the state and update structs.
module mahl_hilo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  mahl_pkg::hilo_upd_t  upd,
  output mahl_pkg::hilo_state_t state
);
  import mahl_pkg::*;

  logic [WordW-1:0] hi_r, hi_nxt;
  logic [WordW-1:0] lo_r, lo_nxt;
  logic             pending_r, pending_nxt;

  always_comb begin
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    pending_nxt = pending_r;
    if (en) begin
      if (upd.write_product) begin
        hi_nxt      = upd.hi;
        lo_nxt      = upd.lo;
        pending_nxt = 1'b1;
      end else if (upd.clear_pending) begin
        pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r      <= '0;
      lo_r      <= '0;
      pending_r <= 1'b0;
    end else begin
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      pending_r <= pending_nxt;
    end
  end

  assign state = '{hi: hi_r, lo: lo_r, pending: pending_r};

endmodule

// ----- rtl/mahl_alu.sv -----
// Single-pass ALU datapath: logic, shifts, add/sub with overflow, and the
// 33x33 multiply that feeds HI/LO. Depends on mahl_pkg.
module mahl_alu (
  input  mahl_pkg::in_beat_t    item,
  input  mahl_pkg::hilo_state_t state,
  output mahl_pkg::out_beat_t   res,
  output mahl_pkg::hilo_upd_t   upd
);
  import mahl_pkg::*;

  logic        [WordW-1:0]   a, b, sum, diff;
  logic                      mul_signed;
  logic signed [WordW:0]     ma, mb;
  logic signed [2*WordW+1:0] prod;

  assign a    = item.operand_a;
  assign b    = item.operand_b;
  assign sum  = a + b;
  assign diff = a - b;

  // Extend to 33 bits so one signed multiplier serves mult and multu.
  assign mul_signed = (item.command == CMD_MULT);
  assign ma   = $signed({mul_signed & a[WordW-1], a});
  assign mb   = $signed({mul_signed & b[WordW-1], b});
  assign prod = ma * mb;

  always_comb begin
    res = '0;
    upd = '{write_product: 1'b0, clear_pending: 1'b0,
            hi: prod[2*WordW-1:WordW], lo: prod[WordW-1:0]};
    unique case (item.command)
      CMD_ADD_CHK: begin
        res.result   = sum;
        res.overflow = ~(a[WordW-1] ^ b[WordW-1]) & (a[WordW-1] ^ sum[WordW-1]);
      end
      CMD_ADD_WRAP: res.result = sum;
      CMD_SUB_CHK: begin
        res.result   = diff;
        res.overflow = (a[WordW-1] ^ b[WordW-1]) & (a[WordW-1] ^ diff[WordW-1]);
      end
      CMD_AND:  res.result = a & b;
      CMD_OR:   res.result = a | b;
      CMD_XOR:  res.result = a ^ b;
      CMD_NOR:  res.result = ~(a | b);
      CMD_NAND: res.result = ~(a & b);
      CMD_SLT:  res.result = {{(WordW-1){1'b0}}, item.operand_a < item.operand_b};
      CMD_SLL:  res.result = b << item.shift_amount;
      CMD_SRL:  res.result = b >> item.shift_amount;
      CMD_SRA:  res.result = item.operand_b >>> item.shift_amount;
      CMD_MULT, CMD_MULTU: begin
        res.result         = prod[WordW-1:0];
        res.hilo_overwrite = state.pending;
        upd.write_product  = 1'b1;
      end
      CMD_MFHI: begin
        res.result        = state.hi;
        upd.clear_pending = 1'b1;
      end
      CMD_MFLO: begin
        res.result        = state.lo;
        upd.clear_pending = 1'b1;
      end
      CMD_LUI:  res.result = b << UpperShift;
      default:  res = '0;  // undefined commands: zero result, state untouched
    endcase
  end

endmodule

// ----- rtl/mips_alu_with_hi_lo_core.sv -----
// Top level of the MIPS-style ALU with HI/LO multiply registers.
// Depends on mahl_pkg, mahl_alu and mahl_hilo.
//
// One beat in, one beat out, one per clock when the output side keeps up.
// A beat accepted on in_* is held in the input register, passes through
// the ALU (one 33x33 multiply as the longest path) and lands in the output
// register, from which its result shows on out_*. HI/LO and the pending
// mark update as the beat moves into the output register, so an mfhi or
// mflo right behind a multiply sees the new product. Both registers advance
// together whenever the output is empty or taken; out_stall holds them and
// propagates to in_stall only while the input register is full. Reset
// clears HI, LO and the pending mark.
module mips_alu_with_hi_lo_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mahl_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output mahl_pkg::out_beat_t out_beat
);
  import mahl_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  in_beat_t    s1_beat_r;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_beat_r;
  logic        advance;
  logic        s1_load;
  logic        s1_fire;
  out_beat_t   alu_res;
  hilo_upd_t   hilo_upd;
  hilo_state_t hilo_state;

  // Advance the output register when it is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  // Fill the input register whenever it is empty or draining.
  assign s1_load  = advance || !s1_valid_r;
  assign s1_fire  = s1_valid_r && advance;
  // Hold the input side only while the input register cannot drain.
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s1_load) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load when their side moves, hold otherwise.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_beat_r  <= in_beat;
    end
    if (advance) begin
      out_beat_r <= alu_res;
    end
  end

  mahl_alu u_alu (
    .item  (s1_beat_r),
    .state (hilo_state),
    .res   (alu_res),
    .upd   (hilo_upd)
  );

  // Commit HI/LO only for a real beat moving into the output register.
  mahl_hilo u_hilo (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_fire),
    .upd   (hilo_upd),
    .state (hilo_state)
  );

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ----- rtl/mahl_checker.sv -----
// Port-level checker for mips_alu_with_hi_lo_core, bound to the top level.
// Depends on mahl_pkg for the beat types.
module mahl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mahl_pkg::out_beat_t out_beat
);
  import mahl_pkg::*;

  // Output beat holds while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  // Backpressure reaches the input only through a stalled, full output.
  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall raised without a stalled output beat");

  // Overflow comes from add/sub only, overwrite from multiplies only.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_beat.overflow && out_beat.hilo_overwrite))
    else $error("overflow and hilo_overwrite both set");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind mips_alu_with_hi_lo_core mahl_checker u_mahl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
